FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/twevb_pkg.sv
package twevb_pkg;

  localparam int unsigned MaxGroupDefault = 1024;
  localparam int unsigned StampW = 64;
  localparam int unsigned CodeW = 15;
  localparam logic [CodeW-1:0] TypeMask = 15'h7fff;

  typedef enum logic [1:0] {
    KIND_COMPOSITE = 2'd0,
    KIND_PARAMS    = 2'd1,
    KIND_ABNORMAL  = 2'd2,
    KIND_UNUSED    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    POLICY_FIRST = 2'd0,
    POLICY_LAST  = 2'd1,
    POLICY_AVG   = 2'd2,
    POLICY_RSVD  = 2'd3
  } policy_e;

  typedef enum logic [2:0] {
    REG_WINDOW     = 3'd0,
    REG_NO_BUILD   = 3'd1,
    REG_POLICY     = 3'd2,
    REG_SOURCE     = 3'd3,
    REG_EXPECT     = 3'd4,
    REG_BEGIN_CODE = 3'd5,
    REG_END_CODE   = 3'd6,
    REG_ABN_CODE   = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMP,
    ST_EXTRA,
    ST_JOIN
  } state_e;

endpackage

FILE: rtl/core/timestamp_window_event_builder.sv
// Coincidence-window event builder.
// Input channel (in_valid_i / in_stall_o) carries one transaction per item header:
// action_i (0 data item, 1 end of input), item_type_i and item_stamp_i. The output
// channel (out_valid_o / out_stall_i) carries result records: composite headers,
// the parameters record and the abnormal end, each with last_of_run_o set on the
// final record caused by one input transaction. The user must write
// configuration through cfg_we_i / cfg_index_i / cfg_data_i only while the
// block is idle; the block itself does not enforce this. One item is handled
// at a time; in_stall_o is high from acceptance until the item is fully
// processed. An item that only joins a group passes through the join state;
// one that closes a group emits its composite first, after a restoring divider
// (one quotient bit per cycle) has formed the mean under the average policy.
// Reset clears the open group and run nesting, restores the register defaults
// and arms the parameters record. When the receiver stalls, the finished record
// holds in the output register and the sequencer waits before loading the next.
module timestamp_window_event_builder #(
  parameter int unsigned MAX_GROUP = twevb_pkg::MaxGroupDefault,
  localparam int unsigned CntW = $clog2(MAX_GROUP + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [2:0]                 cfg_index_i,
  input  logic [63:0]                cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       action_i,
  input  logic [15:0]                item_type_i,
  input  logic [63:0]                item_stamp_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 record_kind_o,
  output logic [15:0]                record_type_o,
  output logic [63:0]                record_stamp_o,
  output logic [31:0]                record_source_o,
  output logic [CntW-1:0]            child_count_o,
  output logic [63:0]                param_window_o,
  output logic                       param_flag_o,
  output logic [1:0]                 param_policy_o,
  output logic                       last_of_run_o
);
  import twevb_pkg::*;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_GROUP);
  localparam int unsigned DivCntW = $clog2(StampW);

  // Configuration registers. A write to the expect_barrier register (REG_EXPECT)
  // is accepted and dropped.
  logic [63:0]      window_q;
  logic             no_build_q;
  logic [1:0]       policy_q;
  logic [31:0]      source_q;
  logic [CodeW-1:0] begin_code_q, end_code_q, abn_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q     <= '0;
      no_build_q   <= 1'b0;
      policy_q     <= POLICY_FIRST;
      source_q     <= '0;
      begin_code_q <= CodeW'(1);
      end_code_q   <= CodeW'(2);
      abn_code_q   <= CodeW'(5);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_WINDOW:     window_q     <= cfg_data_i;
        REG_NO_BUILD:   no_build_q   <= cfg_data_i[0];
        REG_POLICY:     policy_q     <= cfg_data_i[1:0];
        REG_SOURCE:     source_q     <= cfg_data_i[31:0];
        REG_EXPECT:     ;
        REG_BEGIN_CODE: begin_code_q <= cfg_data_i[CodeW-1:0] & TypeMask;
        REG_END_CODE:   end_code_q   <= cfg_data_i[CodeW-1:0] & TypeMask;
        REG_ABN_CODE:   abn_code_q   <= cfg_data_i[CodeW-1:0] & TypeMask;
        default:        ;
      endcase
    end
  end

  // Control state.
  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [15:0]        nest_q, nest_d;
  logic               armed_q, armed_d;
  logic               out_valid_q, out_valid_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;

  // Latched item and its decisions.
  logic               act_q, act_d;
  logic [15:0]        itype_q, itype_d;
  logic [63:0]        istamp_q, istamp_d;
  logic               close_q, close_d;
  logic               params_q, params_d;

  // Group state and the divider datapath.
  logic [63:0]        first_q, first_d, last_q, last_d, sum_q, sum_d;
  logic [15:0]        gtype_q, gtype_d;
  logic [63:0]        quo_q, quo_d;
  logic [CntW-1:0]    rem_q, rem_d;

  // Output record register.
  logic [1:0]         kind_q, kind_d;
  logic [15:0]        rtype_q, rtype_d;
  logic [63:0]        rstamp_q, rstamp_d;
  logic [31:0]        rsrc_q, rsrc_d;
  logic [CntW-1:0]    rcnt_q, rcnt_d;
  logic [63:0]        pwin_q, pwin_d;
  logic               pflag_q, pflag_d;
  logic [1:0]         ppol_q, ppol_d;
  logic               rlast_q, rlast_d;

  logic               in_acc, slot_free, is_begin, open, win_over, type_diff, full;
  logic [63:0]        diff;
  logic [CntW:0]      rem_sh, rem_sub;
  logic [15:0]        nest_new;
  logic [CodeW-1:0]   low_type;
  logic               need_extra;

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign open      = (count_q != '0);
  assign is_begin  = (item_type_i == {1'b0, begin_code_q}) && armed_q;
  assign diff      = item_stamp_i - first_q;
  assign win_over  = open && (diff > window_q);
  assign type_diff = open && (gtype_q[14:0] != item_type_i[14:0]);
  assign full      = (count_q >= MaxCnt);

  // One restoring-division step: shift in the next dividend bit, try the count.
  assign rem_sh  = {rem_q, quo_q[63]};
  assign rem_sub = rem_sh - {1'b0, count_q};

  // Run nesting after the composite built from the open group.
  assign low_type = gtype_q[14:0];
  always_comb begin
    nest_new = nest_q;
    if (low_type == begin_code_q) nest_new = nest_new + 16'd1;
    if (low_type == end_code_q)   nest_new = nest_new - 16'd1;
    if (low_type == abn_code_q)   nest_new = '0;
  end

  assign need_extra = act_q ? (nest_new != '0) : params_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    nest_d      = nest_q;
    armed_d     = armed_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_cnt_d   = div_cnt_q;
    act_d       = act_q;
    itype_d     = itype_q;
    istamp_d    = istamp_q;
    close_d     = close_q;
    params_d    = params_q;
    first_d     = first_q;
    last_d      = last_q;
    sum_d       = sum_q;
    gtype_d     = gtype_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    kind_d      = kind_q;
    rtype_d     = rtype_q;
    rstamp_d    = rstamp_q;
    rsrc_d      = rsrc_q;
    rcnt_d      = rcnt_q;
    pwin_d      = pwin_q;
    pflag_d     = pflag_q;
    ppol_d      = ppol_q;
    rlast_d     = rlast_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          act_d    = action_i;
          itype_d  = item_type_i;
          istamp_d = item_stamp_i;
          if (action_i) begin
            close_d  = open;
            params_d = 1'b0;
          end else begin
            close_d  = open && (is_begin || no_build_q || win_over || type_diff || full);
            params_d = is_begin;
            if (is_begin) armed_d = 1'b0;
            if (item_type_i == {1'b0, end_code_q}) armed_d = 1'b1;
          end
          quo_d     = sum_q;
          rem_d     = '0;
          div_cnt_d = '0;
          if (action_i ? open : close_d) begin
            state_d = (policy_q == POLICY_AVG) ? ST_DIV : ST_COMP;
          end else if (action_i) begin
            state_d = (nest_q != '0) ? ST_EXTRA : ST_IDLE;
          end else begin
            state_d = is_begin ? ST_EXTRA : ST_JOIN;
          end
        end
      end
      ST_DIV: begin
        if (!rem_sub[CntW]) begin
          rem_d = rem_sub[CntW-1:0];
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = rem_sh[CntW-1:0];
          quo_d = {quo_q[62:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + DivCntW'(1);
        if (div_cnt_q == DivCntW'(StampW - 1)) state_d = ST_COMP;
      end
      ST_COMP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_COMPOSITE;
          rtype_d     = {1'b1, gtype_q[14:0]};
          case (policy_q)
            POLICY_LAST: rstamp_d = last_q;
            POLICY_AVG:  rstamp_d = quo_q;
            default:     rstamp_d = first_q;
          endcase
          rsrc_d  = source_q;
          rcnt_d  = count_q;
          pwin_d  = '0;
          pflag_d = 1'b0;
          ppol_d  = '0;
          rlast_d = !need_extra;
          nest_d  = nest_new;
          count_d = '0;
          if (need_extra)  state_d = ST_EXTRA;
          else if (act_q)  state_d = ST_IDLE;
          else             state_d = ST_JOIN;
        end
      end
      ST_EXTRA: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          rstamp_d    = '0;
          rsrc_d      = '0;
          rcnt_d      = '0;
          rlast_d     = 1'b1;
          if (act_q) begin
            kind_d  = KIND_ABNORMAL;
            rtype_d = {1'b0, abn_code_q};
            pwin_d  = '0;
            pflag_d = 1'b0;
            ppol_d  = '0;
            state_d = ST_IDLE;
          end else begin
            kind_d  = KIND_PARAMS;
            rtype_d = '0;
            pwin_d  = window_q;
            pflag_d = no_build_q;
            ppol_d  = policy_q;
            state_d = ST_JOIN;
          end
        end
      end
      ST_JOIN: begin
        if (count_q == '0) begin
          first_d = istamp_q;
          sum_d   = istamp_q;
          gtype_d = itype_q;
        end else begin
          sum_d = sum_q + istamp_q;
        end
        last_d  = istamp_q;
        count_d = count_q + CntW'(1);
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      nest_q      <= '0;
      armed_q     <= 1'b1;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
      first_q     <= '0;
      last_q      <= '0;
      sum_q       <= '0;
      gtype_q     <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      nest_q      <= nest_d;
      armed_q     <= armed_d;
      out_valid_q <= out_valid_d;
      div_cnt_q   <= div_cnt_d;
      first_q     <= first_d;
      last_q      <= last_d;
      sum_q       <= sum_d;
      gtype_q     <= gtype_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    itype_q  <= itype_d;
    istamp_q <= istamp_d;
    close_q  <= close_d;
    params_q <= params_d;
    quo_q    <= quo_d;
    rem_q    <= rem_d;
    kind_q   <= kind_d;
    rtype_q  <= rtype_d;
    rstamp_q <= rstamp_d;
    rsrc_q   <= rsrc_d;
    rcnt_q   <= rcnt_d;
    pwin_q   <= pwin_d;
    pflag_q  <= pflag_d;
    ppol_q   <= ppol_d;
    rlast_q  <= rlast_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign record_kind_o   = kind_q;
  assign record_type_o   = rtype_q;
  assign record_stamp_o  = rstamp_q;
  assign record_source_o = rsrc_q;
  assign child_count_o   = rcnt_q;
  assign param_window_o  = pwin_q;
  assign param_flag_o    = pflag_q;
  assign param_policy_o  = ppol_q;
  assign last_of_run_o   = rlast_q;

endmodule

FILE: rtl/core/twevb_checker.sv
`include "assert_macros.svh"

module twevb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        action_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  record_kind_o,
  input logic [15:0] record_type_o,
  input logic [63:0] record_stamp_o
);
  import twevb_pkg::*;

  // A data item always leaves the sequencer busy once it is accepted; an
  // end of input with nothing to close or report can finish at once.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o && !action_i, in_stall_o)
  `ASSERT_NEXT(a_hold_stalled, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(record_stamp_o))
  `ASSERT_SAME(a_kind_legal, clk_i, rst_ni, out_valid_o, record_kind_o != KIND_UNUSED)
  `ASSERT_SAME(a_composite_flag, clk_i, rst_ni, out_valid_o && record_kind_o == KIND_COMPOSITE, record_type_o[15])

endmodule

bind timestamp_window_event_builder twevb_checker u_twevb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .action_i       (action_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .record_kind_o  (record_kind_o),
  .record_type_o  (record_type_o),
  .record_stamp_o (record_stamp_o)
);
